// File: hw/rtl/slstk_pkg.sv
// Package for the searchable LIFO stack: request and status codes,
// plus the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package slstk_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW = 4;
  localparam int unsigned CountOutW = 5;

  // request actions
  localparam logic [ActionW-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ActionW-1:0] ACT_POP    = 2'd1;
  localparam logic [ActionW-1:0] ACT_SEARCH = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY    = 2'd1;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic               latch;       // capture request fields
    logic               push;        // write value on top, count up
    logic               pop;         // count down, read the popped top entry
    logic               srch_first;  // read bottom entry, index to zero
    logic               srch_next;   // read next entry, index up
    logic               respond;     // load result registers
    logic [StatusW-1:0] status;
    logic               take_pop;    // result carries read data
    logic               take_pos;    // result carries search index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic               full;
    logic               empty;
    logic               match;       // registered read data equals value
    logic               last;        // index points at top entry
  } sts_t;

endpackage

// File: hw/rtl/slstk_ctrl.sv
// Controller for the searchable LIFO stack: sequences push, pop and search.
// Depends on slstk_pkg.
`timescale 1ns / 1ps

module slstk_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  slstk_pkg::sts_t  sts_i,
  output slstk_pkg::cmd_t  cmd_o
);
  import slstk_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_POPRD  = 2'd2;
  localparam logic [1:0] S_SEARCH = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        unique case (sts_i.action)
          ACT_PUSH: begin
            cmd_o.respond = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.push   = 1'b1;
              cmd_o.status = ST_OK;
            end
          end
          ACT_POP: begin
            if (sts_i.empty) begin
              cmd_o.respond = 1'b1;
              cmd_o.status  = ST_EMPTY;
            end else begin
              cmd_o.pop = 1'b1;
              state_d   = S_POPRD;
            end
          end
          ACT_SEARCH: begin
            if (sts_i.empty) begin
              cmd_o.respond = 1'b1;
              cmd_o.status  = ST_EMPTY;
            end else begin
              cmd_o.srch_first = 1'b1;
              state_d          = S_SEARCH;
            end
          end
          default: begin
            // unused action: no-op, plain ok
            cmd_o.respond = 1'b1;
            cmd_o.status  = ST_OK;
          end
        endcase
      end
      S_POPRD: begin
        cmd_o.respond  = 1'b1;
        cmd_o.status   = ST_OK;
        cmd_o.take_pop = 1'b1;
        state_d        = S_IDLE;
      end
      S_SEARCH: begin
        if (sts_i.match) begin
          cmd_o.respond  = 1'b1;
          cmd_o.status   = ST_OK;
          cmd_o.take_pos = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.last) begin
          cmd_o.respond = 1'b1;
          cmd_o.status  = ST_NOTFOUND;
          state_d       = S_IDLE;
        end else begin
          cmd_o.srch_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/slstk_dp.sv
// Datapath for the searchable LIFO stack: entry store, count, search index
// and result registers. Depends on slstk_pkg.
`timescale 1ns / 1ps

module slstk_dp #(
  parameter int unsigned DEPTH = slstk_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [slstk_pkg::ActionW-1:0]        action_i,
  input  logic signed [slstk_pkg::ValueW-1:0]  value_i,
  input  slstk_pkg::cmd_t                      cmd_i,
  output slstk_pkg::sts_t                      sts_o,
  output logic                                 done_o,
  output logic [slstk_pkg::StatusW-1:0]        status_o,
  output logic signed [slstk_pkg::ValueW-1:0]  popped_value_o,
  output logic [slstk_pkg::PosW-1:0]           found_position_o,
  output logic [slstk_pkg::CountOutW-1:0]      entry_count_o,
  output logic                                 is_empty_o
);
  import slstk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [ValueW-1:0]  mem [DEPTH];
  logic [ValueW-1:0]  rd_q;
  logic [ActionW-1:0] action_q;
  logic [ValueW-1:0]  value_q;
  logic [CW-1:0]      count_q, count_d, cnt_dec;
  logic [AW-1:0]      idx_q, idx_d, rd_addr;
  logic               rd_en;

  logic               done_q;
  logic [StatusW-1:0] status_q;
  logic [ValueW-1:0]  popped_q;
  logic [PosW-1:0]    pos_q;
  logic [CountOutW-1:0] cnt_out_q;
  logic               empty_q;

  assign cnt_dec = count_q - CW'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = cnt_dec;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    rd_addr = idx_q;
    if (cmd_i.pop) begin
      rd_addr = cnt_dec[AW-1:0];
    end else if (cmd_i.srch_first) begin
      idx_d   = '0;
      rd_addr = '0;
    end else if (cmd_i.srch_next) begin
      idx_d   = idx_q + AW'(1);
      rd_addr = idx_d;
    end
  end

  assign rd_en = cmd_i.pop | cmd_i.srch_first | cmd_i.srch_next;

  // entry store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[AW-1:0]] <= value_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      value_q  <= value_i;
    end
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      status_q  <= cmd_i.status;
      popped_q  <= cmd_i.take_pop ? rd_q : '0;
      pos_q     <= cmd_i.take_pos ? PosW'(idx_q) : '0;
      cnt_out_q <= CountOutW'(count_d);
      empty_q   <= (count_d == '0);
    end
  end

  assign sts_o.action = action_q;
  assign sts_o.full   = (count_q == CW'(DEPTH));
  assign sts_o.empty  = (count_q == '0);
  assign sts_o.match  = (rd_q == value_q);
  assign sts_o.last   = ({1'b0, idx_q} == (AW + 1)'(cnt_dec));

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign popped_value_o   = popped_q;
  assign found_position_o = pos_q;
  assign entry_count_o    = cnt_out_q;
  assign is_empty_o       = empty_q;

endmodule

// File: hw/rtl/searchable_lifo_stack_top.sv
// Top level of the searchable LIFO stack: controller plus datapath.
// Depends on slstk_pkg, slstk_ctrl, slstk_dp.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------------
//  request   | start / busy         | action_i, value_i
//  result    | done_o (one cycle)   | status_o, popped_value_o, found_position_o,
//            |                      | entry_count_o, is_empty_o
//
// A transfer is taken on start while busy is low. Busy stays high through the
// decode state, also the read state on pop and the search state on a search,
// which compares entries one at a time (at most DEPTH) on the single read port
// of the entry store. The result strobe is high in the first cycle with busy low,
// when the next request may already be taken. Reset clears the state, the count
// and done_o; the store needs no clearing pass. The receiver cannot stall results.
`timescale 1ns / 1ps

module searchable_lifo_stack_top #(
  parameter int unsigned DEPTH = slstk_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [slstk_pkg::ActionW-1:0]        action_i,
  input  logic signed [slstk_pkg::ValueW-1:0]  value_i,
  output logic                                 done_o,
  output logic [slstk_pkg::StatusW-1:0]        status_o,
  output logic signed [slstk_pkg::ValueW-1:0]  popped_value_o,
  output logic [slstk_pkg::PosW-1:0]           found_position_o,
  output logic [slstk_pkg::CountOutW-1:0]      entry_count_o,
  output logic                                 is_empty_o
);
  import slstk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slstk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  slstk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (action_i),
    .value_i          (value_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .done_o           (done_o),
    .status_o         (status_o),
    .popped_value_o   (popped_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o),
    .is_empty_o       (is_empty_o)
  );

  // a result is only posted once the controller has gone back to idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always sets the controller busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but controller not busy");

  // an empty report leaves the stack empty
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> is_empty_o)
    else $error("empty status with entries stored");

  // a full report never comes with an empty stack
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> !is_empty_o)
    else $error("full status on empty stack");

endmodule
